### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the coverage pipeline.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LPC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LPC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/lpc_pkg.sv
// ---------------------------------------------------------------------------
// lpc_pkg
// Widths, register codes and item types of the line coverage pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpc_pkg;

   localparam int COORD_FRAC_BITS = 4;
   localparam int COVERAGE_BITS   = 8;
   localparam int PIX_W           = 12;
   localparam int COORD_W         = 16;
   localparam int OPA_W           = 9;
   localparam int OPA_FRAC        = 8;
   localparam int CSR_IDX_W       = 3;

   // datapath widths
   localparam int X_W  = ((PIX_W + COORD_FRAC_BITS > COORD_W) ?
                          PIX_W + COORD_FRAC_BITS : COORD_W) + 1;
   localparam int V_W  = COORD_W + 1;
   localparam int W_W  = X_W + 1;
   localparam int P_W  = V_W + W_W;
   localparam int C1_W = P_W + 1;
   localparam int C2_W = 2 * V_W;
   localparam int NUM_W = 2 * W_W;
   localparam int CR_LIM_W = COORD_FRAC_BITS + 18;

   localparam int COV_S = 1 << COVERAGE_BITS;
   localparam int N_MAX = 3 * COV_S / 2;
   localparam int M_W   = $clog2(N_MAX + 1);
   localparam int COV_W = COVERAGE_BITS + 1;

   localparam int N_W = ((NUM_W > 2 * CR_LIM_W) ? NUM_W : 2 * CR_LIM_W) + 2 * COVERAGE_BITS;
   localparam int D_W = C2_W + 2 * COORD_FRAC_BITS;
   localparam int S_W = ((N_W > 2 * M_W + D_W) ? N_W : 2 * M_W + D_W) + 1;

   localparam logic [OPA_W-1:0] OPA_FULL = OPA_W'(1 << OPA_FRAC);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OPACITY = 3'd4;

   typedef struct packed {
      logic signed [PIX_W-1:0] x;
      logic signed [PIX_W-1:0] y;
      logic                    far;
      logic                    nz;
   } side_type;

   // root search state: largest m with m*m*d < n, plus running m*m*d and m*d
   typedef struct packed {
      side_type         side;
      logic [M_W-1:0]   m;
      logic [S_W-1:0]   p;
      logic [S_W-1:0]   q;
      logic [S_W-1:0]   d;
      logic [S_W-1:0]   n;
   } search_type;

endpackage

`default_nettype wire

### sv/lpc_search_step.sv
// ---------------------------------------------------------------------------
// lpc_search_step
// One registered bit of the ceiling square root search.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpc_search_step #(
   parameter int BIT = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  valid_i,
   input  lpc_pkg::search_type   item_i,
   output logic                  valid_o,
   output lpc_pkg::search_type   item_o
);
   import lpc_pkg::*;

   logic [S_W-1:0] tsq;
   logic           take;
   search_type     item_in;
   search_type     item_ff;
   logic           valid_ff;

   // (m + 2^k)^2 d = m^2 d + 2^(k+1) m d + 2^2k d
   always_comb begin
      tsq     = item_i.p + (item_i.q << (BIT + 1)) + (item_i.d << (2 * BIT));
      take    = tsq < item_i.n;
      item_in = item_i;
      if (take) begin
         item_in.m = item_i.m | (M_W'(1) << BIT);
         item_in.p = tsq;
         item_in.q = item_i.q + (item_i.d << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign valid_o = valid_ff;
   assign item_o  = item_ff;

endmodule

`default_nettype wire

### sv/line_pixel_coverage.sv
// ---------------------------------------------------------------------------
// line_pixel_coverage
// Antialiased coverage of integer pixels by one line segment.
// ---------------------------------------------------------------------------
// Write both endpoints (signed Q12.4) and the opacity (Q1.8) through the csr_
// port while no pixel is in flight, then stream pixel coordinates on req_.
// Each pixel yields one rsp_ item: the coordinates, coverage =
// clamp(1.5 - d, 0, 1) * opacity in Q1.8 (0..256), and covered when that is
// non-zero. d is the exact distance from the pixel centre to the segment,
// taken to the nearer endpoint when the projection falls outside it.
// Throughput is one pixel per clock while rsp_ready does not stall it. The
// pipe has six setup stages (input, differences, products, sums, case
// select, squaring), nine ceiling square root stages (one result bit each),
// a clamp stage and the opacity multiply in the output register. Bubbles
// close up, so req_ready stays high while a result waits as long as the
// pipe has a free slot. Config writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module line_pixel_coverage (
   input  logic                                 clock,
   input  logic                                 reset,
   // config
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lpc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lpc_pkg::COORD_W-1:0]          csr_data,
   // pixels in
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [lpc_pkg::PIX_W-1:0]     req_pixel_x,
   input  logic signed [lpc_pkg::PIX_W-1:0]     req_pixel_y,
   // results out
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [lpc_pkg::PIX_W-1:0]     rsp_out_x,
   output logic signed [lpc_pkg::PIX_W-1:0]     rsp_out_y,
   output logic [lpc_pkg::COV_W-1:0]            rsp_coverage,
   output logic                                 rsp_covered
);
   import lpc_pkg::*;

`include "assert_macros.svh"

   // ---------------- config registers ----------------
   logic signed [COORD_W-1:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   logic [OPA_W-1:0]          opacity_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         end_x_ff   <= '0;
         end_y_ff   <= '0;
         opacity_ff <= OPA_FULL;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_START_X: start_x_ff <= csr_data;
            CSR_START_Y: start_y_ff <= csr_data;
            CSR_END_X:   end_x_ff   <= csr_data;
            CSR_END_Y:   end_y_ff   <= csr_data;
            CSR_OPACITY: opacity_ff <= csr_data[OPA_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- stage enables (bubbles collapse) ----------------
   logic en_a, en_b, en_c, en_d, en_e, en_h, en_o;
   logic va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff, vh_ff, rsp_valid_ff;
   logic [M_W+1:0] en_st;
   logic [M_W:0]   sv;
   search_type     st [M_W+1];

   assign en_o         = !rsp_valid_ff || rsp_ready;
   assign en_h         = !vh_ff || en_o;
   assign en_st[M_W+1] = en_h;

   genvar j;
   generate
      for (j = 0; j <= M_W; j++) begin : g_en
         assign en_st[j] = !sv[j] || en_st[j+1];
      end
   endgenerate

   assign en_e = !ve_ff || en_st[0];
   assign en_d = !vd_ff || en_e;
   assign en_c = !vc_ff || en_d;
   assign en_b = !vb_ff || en_c;
   assign en_a = !va_ff || en_b;
   assign req_ready = en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         vd_ff        <= 1'b0;
         ve_ff        <= 1'b0;
         vf_ff        <= 1'b0;
         vh_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_a)     va_ff        <= req_valid;
         if (en_b)     vb_ff        <= va_ff;
         if (en_c)     vc_ff        <= vb_ff;
         if (en_d)     vd_ff        <= vc_ff;
         if (en_e)     ve_ff        <= vd_ff;
         if (en_st[0]) vf_ff        <= ve_ff;
         if (en_h)     vh_ff        <= sv[M_W];
         if (en_o)     rsp_valid_ff <= vh_ff;
      end
   end

   // search entry valid; the later bits come from the step outputs
   assign sv[0] = vf_ff;

   // ---------------- A: input register ----------------
   logic signed [PIX_W-1:0] xa_ff, ya_ff;

   always_ff @(posedge clock) begin
      if (en_a) begin
         xa_ff <= req_pixel_x;
         ya_ff <= req_pixel_y;
      end
   end

   // ---------------- B: centre and differences ----------------
   logic signed [X_W-1:0]   px, py;
   logic signed [PIX_W-1:0] xb_ff, yb_ff;
   logic signed [V_W-1:0]   vx_in, vy_in, vx_ff, vy_ff;
   logic signed [W_W-1:0]   wx_in, wy_in, ex_in, ey_in;
   logic signed [W_W-1:0]   wx_ff, wy_ff, ex_ff, ey_ff;

   // centre = x * 2^F + 2^(F-1): append the half as fraction bits
   assign px = {{(X_W - PIX_W - COORD_FRAC_BITS){xa_ff[PIX_W-1]}}, xa_ff,
                COORD_FRAC_BITS'(1 << (COORD_FRAC_BITS - 1))};
   assign py = {{(X_W - PIX_W - COORD_FRAC_BITS){ya_ff[PIX_W-1]}}, ya_ff,
                COORD_FRAC_BITS'(1 << (COORD_FRAC_BITS - 1))};

   always_comb begin
      vx_in = V_W'(end_x_ff) - V_W'(start_x_ff);
      vy_in = V_W'(end_y_ff) - V_W'(start_y_ff);
      wx_in = W_W'(px) - W_W'(start_x_ff);
      wy_in = W_W'(py) - W_W'(start_y_ff);
      ex_in = W_W'(px) - W_W'(end_x_ff);
      ey_in = W_W'(py) - W_W'(end_y_ff);
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         xb_ff <= xa_ff;
         yb_ff <= ya_ff;
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         wx_ff <= wx_in;
         wy_ff <= wy_in;
         ex_ff <= ex_in;
         ey_ff <= ey_in;
      end
   end

   // ---------------- C: products ----------------
   logic signed [PIX_W-1:0] xc_ff, yc_ff;
   logic signed [P_W-1:0]   vxwx_ff, vywy_ff, vxwy_ff, vywx_ff;
   logic signed [C2_W-1:0]  vxx_in, vyy_in;
   logic signed [NUM_W-1:0] wxx_in, wyy_in, exx_in, eyy_in;
   logic [C2_W-1:0]         vxx_ff, vyy_ff;
   logic [NUM_W-1:0]        wxx_ff, wyy_ff, exx_ff, eyy_ff;

   always_comb begin
      vxx_in = C2_W'(vx_ff) * C2_W'(vx_ff);
      vyy_in = C2_W'(vy_ff) * C2_W'(vy_ff);
      wxx_in = NUM_W'(wx_ff) * NUM_W'(wx_ff);
      wyy_in = NUM_W'(wy_ff) * NUM_W'(wy_ff);
      exx_in = NUM_W'(ex_ff) * NUM_W'(ex_ff);
      eyy_in = NUM_W'(ey_ff) * NUM_W'(ey_ff);
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         xc_ff   <= xb_ff;
         yc_ff   <= yb_ff;
         vxwx_ff <= P_W'(vx_ff) * P_W'(wx_ff);
         vywy_ff <= P_W'(vy_ff) * P_W'(wy_ff);
         vxwy_ff <= P_W'(vx_ff) * P_W'(wy_ff);
         vywx_ff <= P_W'(vy_ff) * P_W'(wx_ff);
         vxx_ff  <= vxx_in;
         vyy_ff  <= vyy_in;
         wxx_ff  <= wxx_in;
         wyy_ff  <= wyy_in;
         exx_ff  <= exx_in;
         eyy_ff  <= eyy_in;
      end
   end

   // ---------------- D: dot, length, cross, point distances ----------------
   logic signed [PIX_W-1:0] xd_ff, yd_ff;
   logic signed [C1_W-1:0]  c1_ff, cr_ff;
   logic [C2_W-1:0]         c2_ff;
   logic [NUM_W-1:0]        ns_ff, ne_ff;

   always_ff @(posedge clock) begin
      if (en_d) begin
         xd_ff <= xc_ff;
         yd_ff <= yc_ff;
         c1_ff <= C1_W'(vxwx_ff) + C1_W'(vywy_ff);
         cr_ff <= C1_W'(vxwy_ff) - C1_W'(vywx_ff);
         c2_ff <= vxx_ff + vyy_ff;
         ns_ff <= wxx_ff + wyy_ff;
         ne_ff <= exx_ff + eyy_ff;
      end
   end

   // ---------------- E: region select ----------------
   logic                    c1_pos, c2_le, perp_in;
   logic [C1_W-1:0]         cr_abs;
   logic signed [PIX_W-1:0] xe_ff, ye_ff;
   logic                    perp_ff, far_ff;
   logic [NUM_W-1:0]        num_ff;
   logic [C2_W-1:0]         c2e_ff;
   logic [CR_LIM_W-1:0]     cre_ff;

   // endpoints win ties, so a zero-length segment never reaches the cross term
   always_comb begin
      c1_pos  = c1_ff > 0;
      c2_le   = C1_W'(c2_ff) <= $unsigned(c1_ff);
      perp_in = c1_pos && !c2_le;
      cr_abs  = cr_ff[C1_W-1] ? $unsigned(-cr_ff) : $unsigned(cr_ff);
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         xe_ff   <= xd_ff;
         ye_ff   <= yd_ff;
         perp_ff <= perp_in;
         far_ff  <= perp_in && (|cr_abs[C1_W-1:CR_LIM_W]);
         num_ff  <= c1_pos ? ne_ff : ns_ff;
         c2e_ff  <= c2_ff;
         cre_ff  <= cr_abs[CR_LIM_W-1:0];
      end
   end

   // ---------------- F: squared distance as n / d ----------------
   logic [2*CR_LIM_W-1:0] cr_sq;
   search_type            sf_in, sf_ff;

   always_comb begin
      cr_sq = (2*CR_LIM_W)'(cre_ff) * (2*CR_LIM_W)'(cre_ff);
      sf_in.side.x = xe_ff;
      sf_in.side.y = ye_ff;
      sf_in.side.far = far_ff;
      sf_in.m = '0;
      sf_in.p = '0;
      sf_in.q = '0;
      if (perp_ff) begin
         sf_in.n = S_W'(cr_sq) << (2 * COVERAGE_BITS);
         sf_in.d = S_W'(c2e_ff) << (2 * COORD_FRAC_BITS);
      end else begin
         sf_in.n = S_W'(num_ff) << (2 * COVERAGE_BITS);
         sf_in.d = S_W'(1) << (2 * COORD_FRAC_BITS);
      end
      sf_in.side.nz = sf_in.n != '0;
   end

   always_ff @(posedge clock) begin
      if (en_st[0]) begin
         sf_ff <= sf_in;
      end
   end

   assign st[0] = sf_ff;

   // ---------------- ceiling root search, MSB first ----------------
   generate
      for (j = 0; j < M_W; j++) begin : g_step
         lpc_search_step #(.BIT(M_W - 1 - j)) u_step (
            .clock   (clock),
            .reset   (reset),
            .en      (en_st[j+1]),
            .valid_i (sv[j]),
            .item_i  (st[j]),
            .valid_o (sv[j+1]),
            .item_o  (st[j+1])
         );
      end
   endgenerate

   // ---------------- H: clamp 1.5 - d ----------------
   localparam logic [M_W:0]   NMAX_V = (M_W+1)'(N_MAX);
   localparam logic [COV_W-1:0] COV_S_V = COV_W'(COV_S);

   logic [M_W:0]            n_ceil, n_diff;
   logic [COV_W-1:0]        a_in, a_ff;
   logic signed [PIX_W-1:0] xh_ff, yh_ff;

   always_comb begin
      n_ceil = (M_W+1)'(st[M_W].m) + (M_W+1)'(1);
      n_diff = NMAX_V - n_ceil;
      if (st[M_W].side.far) begin
         a_in = '0;
      end else if (!st[M_W].side.nz) begin
         a_in = COV_S_V;
      end else if (n_ceil > NMAX_V) begin
         a_in = '0;
      end else if (n_diff > (M_W+1)'(COV_S)) begin
         a_in = COV_S_V;
      end else begin
         a_in = COV_W'(n_diff);
      end
   end

   always_ff @(posedge clock) begin
      if (en_h) begin
         xh_ff <= st[M_W].side.x;
         yh_ff <= st[M_W].side.y;
         a_ff  <= a_in;
      end
   end

   // ---------------- O: opacity scale, result register ----------------
   logic [OPA_W-1:0]       opa_sat;
   logic [COV_W+OPA_W-1:0] cov_prod;
   logic [COV_W-1:0]       cov_in, cov_ff;
   logic signed [PIX_W-1:0] xo_ff, yo_ff;

   always_comb begin
      opa_sat  = (opacity_ff > OPA_FULL) ? OPA_FULL : opacity_ff;
      cov_prod = (COV_W+OPA_W)'(a_ff) * (COV_W+OPA_W)'(opa_sat);
      cov_in   = cov_prod[OPA_FRAC +: COV_W];
   end

   always_ff @(posedge clock) begin
      if (en_o) begin
         xo_ff  <= xh_ff;
         yo_ff  <= yh_ff;
         cov_ff <= cov_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_x    = xo_ff;
   assign rsp_out_y    = yo_ff;
   assign rsp_coverage = cov_ff;
   assign rsp_covered  = cov_ff != '0;

   // ---------------- checks ----------------
   `LPC_ASSERT_IMP(a_cov_range, clock, reset, rsp_valid_ff, cov_ff <= COV_S_V,
      "coverage above full scale")
   `LPC_ASSERT_NXT(a_out_load, clock, reset, vh_ff && en_o, rsp_valid_ff,
      "clamped item lost before result register")
   `LPC_ASSERT_NXT(a_in_load, clock, reset, req_valid && req_ready, va_ff,
      "accepted item not captured")
   `LPC_ASSERT_IMP(a_far_zero, clock, reset, vh_ff && $past(en_h) && $past(sv[M_W])
      && $past(st[M_W].side.far), a_ff == '0, "far pixel given coverage")

endmodule

`default_nettype wire

### sim/line_pixel_coverage_tb.sv
// ---------------------------------------------------------------------------
// line_pixel_coverage_tb
// Self-checking bench for the line segment pixel coverage pipeline.
// ---------------------------------------------------------------------------
// A directed table covers reset values, coordinate extremes, opacity
// saturation, a degenerate segment and the three distance cases. Random
// phases follow, each with a fresh segment and opacity. In each phase most
// pixels fall in the segment's bounding box, a few anywhere. Every result
// is checked against a typed row or an exact integer calculator held here.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_pixel_coverage_tb;

   import lpc_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 24;     // pipe latency plus margin
   localparam int PHASE_ITEMS    = 205;
   localparam int NUM_PHASES     = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;   // unmapped index

   typedef enum logic { ROW_CSR, ROW_PIX } row_kind_type;

   typedef struct {
      row_kind_type kind;
      int           a;        // csr index or pixel x
      int           b;        // csr data or pixel y
      bit           typed;    // expected coverage given in the row
      int           cov;
   } stim_row_type;

   typedef struct packed {
      logic signed [PIX_W-1:0] x;
      logic signed [PIX_W-1:0] y;
      logic [COV_W-1:0]        cov;
      logic                    covered;
   } pixel_cov_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [COORD_W-1:0]          csr_data = '0;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic signed [PIX_W-1:0]     req_pixel_x = '0;
   logic signed [PIX_W-1:0]     req_pixel_y = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [PIX_W-1:0]     rsp_out_x;
   logic signed [PIX_W-1:0]     rsp_out_y;
   logic [COV_W-1:0]            rsp_coverage;
   logic                        rsp_covered;

   line_pixel_coverage u_dut (.*);

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // local copy of the segment registers
   longint seg_sx, seg_sy, seg_ex, seg_ey;
   int     seg_opa;

   pixel_cov_type expected_cov[$];
   int            errors = 0;
   int            idle_pct = 0;      // sender gaps, percent of cycles
   int            stall_pct = 0;     // receiver stalls, percent of cycles

   // ceiling root search: a in [0, S] for d^2 = num / den
   function automatic int cover_amount(bit [127:0] num, bit [127:0] den);
      bit [127:0] lo, hi, mid;
      lo = 0;
      hi = N_MAX + 1;
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (mid * mid * den >= num * (COV_S * COV_S)) hi = mid;
         else lo = mid + 1;
      end
      if (lo > N_MAX) return 0;
      return (N_MAX - lo > COV_S) ? COV_S : int'(N_MAX - lo);
   endfunction

   function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic pixel_cov_type pixel_coverage(int x, int y);
      longint px, py, vx, vy, wx, wy, c1, c2, ux, uy, cr;
      int a, opa, cov;
      pixel_cov_type r;
      px = longint'(x) * (1 << COORD_FRAC_BITS) + (1 << (COORD_FRAC_BITS - 1));
      py = longint'(y) * (1 << COORD_FRAC_BITS) + (1 << (COORD_FRAC_BITS - 1));
      vx = seg_ex - seg_sx;
      vy = seg_ey - seg_sy;
      wx = px - seg_sx;
      wy = py - seg_sy;
      c1 = vx * wx + vy * wy;
      c2 = vx * vx + vy * vy;
      if (c1 <= 0) begin
         // before the start, or a point segment
         ux = mag(wx);
         uy = mag(wy);
         a = cover_amount(ux * ux + uy * uy, 1 << (2 * COORD_FRAC_BITS));
      end else if (c2 <= c1) begin
         ux = mag(px - seg_ex);
         uy = mag(py - seg_ey);
         a = cover_amount(ux * ux + uy * uy, 1 << (2 * COORD_FRAC_BITS));
      end else begin
         cr = mag(vx * wy - vy * wx);
         if (cr >= (longint'(1) << CR_LIM_W)) a = 0;
         else a = cover_amount(cr * cr, c2 * (1 << (2 * COORD_FRAC_BITS)));
      end
      opa = (seg_opa > 256) ? 256 : seg_opa;
      cov = (a * opa) >> OPA_FRAC;
      r.x = x[PIX_W-1:0];
      r.y = y[PIX_W-1:0];
      r.cov = cov[COV_W-1:0];
      r.covered = (cov > 0);
      return r;
   endfunction

   task automatic report(string what, int got, int want);
      $display("%0t  %s: got %0d, want %0d", $realtime, what, got, want);
      errors++;
   endtask

   // receiver stalls
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   // result checker: oldest expectation first
   always @(posedge clock) begin
      pixel_cov_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cov.size() == 0) begin
            report("unexpected item, x", rsp_out_x, 0);
         end else begin
            want = expected_cov.pop_front();
            if (rsp_out_x !== want.x) report("out_x", rsp_out_x, want.x);
            if (rsp_out_y !== want.y) report("out_y", rsp_out_y, want.y);
            if (rsp_coverage !== want.cov) report("coverage", rsp_coverage, want.cov);
            if (rsp_covered !== want.covered)
               report("covered", rsp_covered, want.covered);
         end
      end
   end

   // watchdog: cycles without any handshake
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("line_pixel_coverage: mismatch");
            $finish;
         end
      end
   end

   // gap before an item; drops valid only when a gap is taken
   task automatic sender_gap();
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
   endtask

   // let the pipe empty before touching registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_cov.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // the wait after each write keeps valid low between writes
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int value);
      logic rdy;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[COORD_W-1:0];
      do begin
         @(negedge clock);
         rdy = csr_ready;
         @(posedge clock);
      end while (!rdy);
      csr_valid <= 1'b0;
      case (idx)
         CSR_START_X: seg_sx = longint'(signed'(value[COORD_W-1:0]));
         CSR_START_Y: seg_sy = longint'(signed'(value[COORD_W-1:0]));
         CSR_END_X:   seg_ex = longint'(signed'(value[COORD_W-1:0]));
         CSR_END_Y:   seg_ey = longint'(signed'(value[COORD_W-1:0]));
         CSR_OPACITY: seg_opa = value & 'h1FF;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_pixel(int x, int y, bit typed, int cov);
      logic rdy;
      pixel_cov_type want;
      sender_gap();
      req_valid   <= 1'b1;
      req_pixel_x <= x[PIX_W-1:0];
      req_pixel_y <= y[PIX_W-1:0];
      do begin
         @(negedge clock);
         rdy = req_ready;
         @(posedge clock);
      end while (!rdy);
      want = pixel_coverage(x, y);
      if (typed) begin
         want.cov = cov[COV_W-1:0];
         want.covered = (cov > 0);
      end
      expected_cov.push_back(want);
   endtask

   function automatic int clamp_pix(longint v);
      if (v < -2048) return -2048;
      if (v > 2047) return 2047;
      return int'(v);
   endfunction

   // directed rows; reset state is a point segment at the origin, opacity 1
   stim_row_type directed[] = '{
      '{ROW_PIX, 0, 0, 1, 202},            // centre 0.707 from the point
      '{ROW_PIX, -1, -1, 1, 202},
      '{ROW_PIX, -2048, -2048, 1, 0},
      '{ROW_PIX, 2047, 2047, 1, 0},
      '{ROW_PIX, -2048, 2047, 1, 0},
      '{ROW_PIX, 2047, -2048, 1, 0},
      '{ROW_CSR, CSR_OPACITY, 511, 0, 0},  // saturates to fully opaque
      '{ROW_PIX, 0, 0, 1, 202},
      '{ROW_CSR, CSR_OPACITY, 0, 0, 0},
      '{ROW_PIX, 0, 0, 1, 0},
      '{ROW_CSR, CSR_OPACITY, 128, 0, 0},
      '{ROW_PIX, 0, 0, 0, 0},
      '{ROW_CSR, CSR_START_X, -32768, 0, 0},
      '{ROW_CSR, CSR_START_Y, -32768, 0, 0},
      '{ROW_CSR, CSR_END_X, 32767, 0, 0},
      '{ROW_CSR, CSR_END_Y, 32767, 0, 0},
      '{ROW_PIX, 0, 0, 0, 0},
      '{ROW_PIX, 5, -5, 0, 0},
      '{ROW_PIX, 100, 102, 0, 0},
      '{ROW_CSR, CSR_SPARE, 'hFFFF, 0, 0}, // unmapped, no effect
      '{ROW_CSR, CSR_START_X, 0, 0, 0},    // horizontal run 0..10 on row 0
      '{ROW_CSR, CSR_START_Y, 0, 0, 0},
      '{ROW_CSR, CSR_END_X, 160, 0, 0},
      '{ROW_CSR, CSR_END_Y, 0, 0, 0},
      '{ROW_CSR, CSR_OPACITY, 256, 0, 0},
      '{ROW_PIX, -3, 0, 0, 0},             // before the start
      '{ROW_PIX, 5, 0, 0, 0},              // along the segment
      '{ROW_PIX, 12, 0, 0, 0},             // past the end
      '{ROW_PIX, 5, 1, 0, 0},
      '{ROW_PIX, 5, -2, 0, 0},
      '{ROW_PIX, -2048, 0, 0, 0}
   };

   initial begin
      longint cx, cy, bx0, bx1, by0, by1;
      int sx, sy, ex, ey, opa, x, y;
      seg_sx = 0; seg_sy = 0; seg_ex = 0; seg_ey = 0; seg_opa = 256;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) begin
            wait_idle();
            write_csr(directed[i].a[CSR_IDX_W-1:0], directed[i].b);
         end else begin
            send_pixel(directed[i].a, directed[i].b, directed[i].typed, directed[i].cov);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         // idling modes in turn: none, sender, receiver, both
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 73; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 73; end
            default: begin idle_pct = 8; stall_pct = 8; end
         endcase
         cx = $urandom_range(60000) - 30000;
         cy = $urandom_range(60000) - 30000;
         sx = int'(cx) + $urandom_range(640) - 320;
         sy = int'(cy) + $urandom_range(640) - 320;
         ex = int'(cx) + $urandom_range(640) - 320;
         ey = int'(cy) + $urandom_range(640) - 320;
         opa = $urandom_range(511);
         if (ph == 1) begin sx = 32767; sy = -32768; ex = -32768; ey = 32767; end
         if (ph == 3) opa = 0;
         if (ph == 4) opa = 256;
         if (ph == 5) begin ex = sx; ey = sy; end    // point segment
         write_csr(CSR_START_X, sx);
         write_csr(CSR_START_Y, sy);
         write_csr(CSR_END_X, ex);
         write_csr(CSR_END_Y, ey);
         write_csr(CSR_OPACITY, opa);
         if (ph == 6) write_csr(CSR_SPARE, $urandom_range(65535));
         // bounding box in whole pixels, widened by three
         bx0 = ((seg_sx < seg_ex) ? seg_sx : seg_ex) / 16 - 3;
         bx1 = ((seg_sx > seg_ex) ? seg_sx : seg_ex) / 16 + 3;
         by0 = ((seg_sy < seg_ey) ? seg_sy : seg_ey) / 16 - 3;
         by1 = ((seg_sy > seg_ey) ? seg_sy : seg_ey) / 16 + 3;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(9) < 8) begin
               x = clamp_pix(bx0 + $urandom_range(int'(bx1 - bx0)));
               y = clamp_pix(by0 + $urandom_range(int'(by1 - by0)));
            end else begin
               x = int'(signed'(12'($urandom())));
               y = int'(signed'(12'($urandom())));
            end
            send_pixel(x, y, 0, 0);
         end
      end

      req_valid <= 1'b0;
      while (expected_cov.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("line_pixel_coverage: match");
      else
         $display("line_pixel_coverage: mismatch");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
+incdir+sv
sv/lpc_pkg.sv
sv/lpc_search_step.sv
sv/line_pixel_coverage.sv
sim/line_pixel_coverage_tb.sv
